[design/cdpd_pkg.sv]
package cdpd_pkg;

	localparam int DW       = 32;
	localparam int FB       = 16;
	localparam int CFG_W    = 31;
	localparam int NUM_REGS = 6;
	localparam int IDX_W    = 3;

	typedef logic signed [DW-1:0] fix_t;
	typedef logic [CFG_W-1:0]     cfg_t;

	typedef enum logic [IDX_W-1:0] {
		REG_CART_MASS  = 0,
		REG_MASS_ONE   = 1,
		REG_MASS_TWO   = 2,
		REG_LENGTH_ONE = 3,
		REG_LENGTH_TWO = 4,
		REG_GRAVITY    = 5
	} reg_idx_t;

	localparam cfg_t RST_CART_MASS  = CFG_W'(65536000);
	localparam cfg_t RST_MASS_ONE   = CFG_W'(6553600);
	localparam cfg_t RST_MASS_TWO   = CFG_W'(6553600);
	localparam cfg_t RST_LENGTH_ONE = CFG_W'(1310720);
	localparam cfg_t RST_LENGTH_TWO = CFG_W'(655360);
	localparam cfg_t RST_GRAVITY    = CFG_W'(642908);

	localparam fix_t FIX_MAX = fix_t'({1'b0, {(DW-1){1'b1}}});
	localparam fix_t FIX_MIN = fix_t'({1'b1, {(DW-1){1'b0}}});
	localparam logic signed [DW:0] WIDE_MAX = {2'b00, {(DW-1){1'b1}}};
	localparam logic signed [DW:0] WIDE_MIN = {2'b11, {(DW-1){1'b0}}};
	localparam logic [2*DW-1:0] MAG_MAX = {{(DW+1){1'b0}}, {(DW-1){1'b1}}};

	localparam longint PI_Q30        = 64'sd3373259426;
	localparam longint HALF_PI_Q30   = 64'sd1686629713;
	localparam longint INV6_Q30      = 64'sd178956971;
	localparam longint INV120_Q30    = 64'sd8947849;
	localparam longint INV5040_Q30   = 64'sd213044;
	localparam longint INV362880_Q30 = 64'sd2959;

	function automatic longint from_q30(input longint c);
		if (FB == 30) return c;
		return (c + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
	endfunction

	localparam longint PI_L   = from_q30(PI_Q30);
	localparam longint HALF_L = from_q30(HALF_PI_Q30);
	localparam longint TP_L   = 2 * PI_L;

	localparam int TP_LOG = $clog2(TP_L);
	localparam int AW     = TP_LOG + 2;
	localparam int RK     = DW + TP_LOG - 1;
	localparam int QW     = DW - TP_LOG + 1;

	typedef logic signed [AW-1:0] ang_t;

	localparam ang_t PI_A   = ang_t'(PI_L);
	localparam ang_t HALF_A = ang_t'(HALF_L);
	localparam ang_t TP_A   = ang_t'(TP_L);
	localparam ang_t OFFSET = ang_t'((64'sd1 <<< (DW - 1)) % TP_L);
	localparam logic [TP_LOG:0] TP_U  = (TP_LOG+1)'(TP_L);
	localparam logic [DW-1:0]   RECIP = DW'((64'sd1 <<< RK) / TP_L);

	localparam fix_t C3  = fix_t'(from_q30(INV6_Q30));
	localparam fix_t C5  = fix_t'(from_q30(INV120_Q30));
	localparam fix_t C7  = fix_t'(from_q30(INV5040_Q30));
	localparam fix_t C9  = fix_t'(from_q30(INV362880_Q30));
	localparam fix_t ONE = fix_t'(64'sd1 <<< FB);

	localparam int DQ_W      = DW + FB;
	localparam int DIV_BPS   = 2;
	localparam int DIV_STEPS = DQ_W / DIV_BPS;
	localparam int DIV_LAT   = DIV_STEPS + 2;

	typedef struct packed {
		fix_t       frc;
		fix_t       vel;
		fix_t [1:0] w;
	} pass_t;

	typedef struct packed {
		pass_t      pass;
		fix_t [1:0] c;
		fix_t [1:0] gs;
	} side1_t;

	typedef struct packed {
		pass_t pass;
		fix_t  acc;
	} side2_t;

	function automatic logic [DW-1:0] fix_mag(input fix_t a);
		logic [DW-1:0] u;
		u = a;
		return a[DW-1] ? ~u + 1'b1 : u;
	endfunction

	function automatic fix_t from_mag(input logic neg, input logic [2*DW-1:0] mag);
		if (!neg) begin
			if (mag > MAG_MAX) return FIX_MAX;
			return fix_t'(mag[DW-1:0]);
		end
		if (mag > MAG_MAX) return FIX_MIN;
		return fix_t'(~mag[DW-1:0] + 1'b1);
	endfunction

	function automatic fix_t fmul(input fix_t a, input fix_t b);
		logic [2*DW-1:0] p;
		p = {{DW{1'b0}}, fix_mag(a)} * {{DW{1'b0}}, fix_mag(b)};
		return from_mag(a[DW-1] ^ b[DW-1], p >> FB);
	endfunction

	function automatic fix_t sat_wide(input logic signed [DW:0] v);
		if (v > WIDE_MAX) return FIX_MAX;
		if (v < WIDE_MIN) return FIX_MIN;
		return fix_t'(v[DW-1:0]);
	endfunction

	function automatic fix_t sadd(input fix_t a, input fix_t b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		return sat_wide(s);
	endfunction

	function automatic fix_t ssub(input fix_t a, input fix_t b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} - {b[DW-1], b};
		return sat_wide(s);
	endfunction

endpackage

[design/cdpd_div.sv]
module cdpd_div (
	input  logic            clk,
	input  logic            en,
	input  cdpd_pkg::fix_t  num,
	input  cdpd_pkg::fix_t  den,
	output cdpd_pkg::fix_t  quo
);
	import cdpd_pkg::*;

	typedef struct packed {
		logic [DW-1:0]   rem;
		logic [DQ_W-1:0] dq;
	} div_st_t;

	div_st_t       st_q   [DIV_STEPS+1];
	logic [DW-1:0] dm_q   [DIV_STEPS];
	logic          neg_q  [DIV_STEPS+1];
	logic          dz_q   [DIV_STEPS+1];
	logic          npos_q [DIV_STEPS+1];
	logic          nneg_q [DIV_STEPS+1];

	function automatic div_st_t div_step(input div_st_t s, input logic [DW-1:0] dm);
		div_st_t     o;
		logic [DW:0] t;
		o = s;
		for (int b = 0; b < DIV_BPS; b++) begin
			t = {o.rem, o.dq[DQ_W-1]};
			if (t >= {1'b0, dm}) begin
				o.rem = DW'(t - {1'b0, dm});
				o.dq  = {o.dq[DQ_W-2:0], 1'b1};
			end else begin
				o.rem = t[DW-1:0];
				o.dq  = {o.dq[DQ_W-2:0], 1'b0};
			end
		end
		return o;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0].rem <= '0;
			st_q[0].dq  <= {fix_mag(num), {FB{1'b0}}};
			dm_q[0]     <= fix_mag(den);
			neg_q[0]    <= num[DW-1] ^ den[DW-1];
			dz_q[0]     <= (den == '0);
			npos_q[0]   <= !num[DW-1] && (num != '0);
			nneg_q[0]   <= num[DW-1];
			for (int i = 0; i < DIV_STEPS; i++) begin
				st_q[i+1]   <= div_step(st_q[i], dm_q[i]);
				neg_q[i+1]  <= neg_q[i];
				dz_q[i+1]   <= dz_q[i];
				npos_q[i+1] <= npos_q[i];
				nneg_q[i+1] <= nneg_q[i];
				if (i < DIV_STEPS - 1) dm_q[i+1] <= dm_q[i];
			end
			if (dz_q[DIV_STEPS]) begin
				quo <= npos_q[DIV_STEPS] ? FIX_MAX : (nneg_q[DIV_STEPS] ? FIX_MIN : '0);
			end else begin
				quo <= from_mag(neg_q[DIV_STEPS], (2*DW)'(st_q[DIV_STEPS].dq));
			end
		end
	end

endmodule

[design/cart_double_pendulum_derivative.sv]
// Throughput: one request per cycle; the whole pipeline holds while the result is stalled.
// The depth is set by the two 24-stage quotient pipelines (two quotient bits per stage).
// Reset clears the valid bits and loads the register defaults; data registers are not reset.
module cart_double_pendulum_derivative (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cdpd_pkg::IDX_W-1:0]   cfg_index,
	input  cdpd_pkg::cfg_t               cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  cdpd_pkg::fix_t               force_req,
	input  cdpd_pkg::fix_t               cart_position,
	input  cdpd_pkg::fix_t               cart_velocity,
	input  cdpd_pkg::fix_t               angle_one,
	input  cdpd_pkg::fix_t               rate_one,
	input  cdpd_pkg::fix_t               angle_two,
	input  cdpd_pkg::fix_t               rate_two,
	output logic                         out_valid,
	input  logic                         out_stall,
	output cdpd_pkg::fix_t               d_position,
	output cdpd_pkg::fix_t               d_velocity,
	output cdpd_pkg::fix_t               d_angle_one,
	output cdpd_pkg::fix_t               d_rate_one,
	output cdpd_pkg::fix_t               d_angle_two,
	output cdpd_pkg::fix_t               d_rate_two
);
	import cdpd_pkg::*;

	localparam int PRE = 14;
	localparam int LAT = PRE + DIV_LAT + 1 + DIV_LAT + 1;

	cfg_t cart_mass_q, mass_one_q, mass_two_q, length_one_q, length_two_q, gravity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_mass_q  <= RST_CART_MASS;
			mass_one_q   <= RST_MASS_ONE;
			mass_two_q   <= RST_MASS_TWO;
			length_one_q <= RST_LENGTH_ONE;
			length_two_q <= RST_LENGTH_TWO;
			gravity_q    <= RST_GRAVITY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CART_MASS:  cart_mass_q  <= cfg_data;
				REG_MASS_ONE:   mass_one_q   <= cfg_data;
				REG_MASS_TWO:   mass_two_q   <= cfg_data;
				REG_LENGTH_ONE: length_one_q <= cfg_data;
				REG_LENGTH_TWO: length_two_q <= cfg_data;
				REG_GRAVITY:    gravity_q    <= cfg_data;
				default: begin end
			endcase
		end
	end

	fix_t       cm_f, g_f;
	fix_t [1:0] m_f, l_f;

	assign cm_f = fix_t'(cart_mass_q);
	assign g_f  = fix_t'(gravity_q);
	assign m_f  = {fix_t'(mass_two_q), fix_t'(mass_one_q)};
	assign l_f  = {fix_t'(length_two_q), fix_t'(length_one_q)};

	logic           en;
	logic [LAT-1:0] vld_q;

	assign en        = !out_valid || !out_stall;
	assign in_stall  = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// angle reduction: offset to unsigned, quotient by reciprocal, one correction
	fix_t [1:0]       ang_in;
	logic [DW-1:0]    u_in   [2];
	logic [2*DW-1:0]  prod   [2];
	logic [TP_LOG:0]  u_s1   [2];
	logic [QW-1:0]    qe_s1  [2];
	logic [QW+TP_LOG:0] qt   [2];
	logic [TP_LOG:0]  rw     [2];
	logic [TP_LOG-1:0] rm_nx [2];
	logic [TP_LOG-1:0] rm_s2 [2];
	ang_t             rd     [2];
	ang_t             rc     [2];
	ang_t             arg_nx [4];
	ang_t             arg_s3 [4];

	assign ang_in = {angle_two, angle_one};

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			u_in[k]  = {~ang_in[k][DW-1], ang_in[k][DW-2:0]};
			prod[k]  = {{DW{1'b0}}, u_in[k]} * {{DW{1'b0}}, RECIP};
			qt[k]    = qe_s1[k] * TP_U;
			rw[k]    = u_s1[k] - qt[k][TP_LOG:0];
			rm_nx[k] = (rw[k] >= TP_U) ? TP_LOG'(rw[k] - TP_U) : rw[k][TP_LOG-1:0];
			rd[k]    = ang_t'(rm_s2[k]) - OFFSET;
			if (rd[k] < 0) rd[k] = rd[k] + TP_A;
			if (rd[k] > PI_A) rd[k] = rd[k] - TP_A;
			rc[k] = rd[k] + HALF_A;
			if (rc[k] > PI_A) rc[k] = rc[k] - TP_A;
			arg_nx[2*k]   = rd[k];
			arg_nx[2*k+1] = rc[k];
		end
	end

	function automatic fix_t fold(input ang_t a);
		if (a > HALF_A) return fix_t'(PI_A - a);
		if (a < -HALF_A) return fix_t'(-PI_A - a);
		return fix_t'(a);
	endfunction

	pass_t      pass_s [PRE];
	fix_t [3:0] f_s4, f_s5, f_s6, f_s7, f_s8;
	fix_t [3:0] r2_s4, r2_s5, r2_s6, r2_s7;
	fix_t [3:0] t_s5, t_s6, t_s7, t_s8, sc_s9;
	fix_t [1:0] p_s10, q_s10, wsq_s10, ml_s10, gs_s10, s_s10, c_s10;
	fix_t [1:0] a_s11, b_s11, e_s11, s_s11, c_s11, gs_s11;
	fix_t [1:0] ct_s12, c_s12, gs_s12, ct_s13, c_s13, gs_s13, c_s14, gs_s14;
	fix_t       gsum_s12, den_s12, gt_s13, den_s13, num_s14, den_s14;

	always_ff @(posedge clk) begin
		if (en) begin
			pass_s[0] <= '{frc: force_req, vel: cart_velocity, w: {rate_two, rate_one}};
			for (int i = 1; i < PRE; i++) pass_s[i] <= pass_s[i-1];
			for (int k = 0; k < 2; k++) begin
				u_s1[k]  <= u_in[k][TP_LOG:0];
				qe_s1[k] <= prod[k][RK+QW-1:RK];
				rm_s2[k] <= rm_nx[k];
			end
			for (int j = 0; j < 4; j++) begin
				arg_s3[j] <= arg_nx[j];
				f_s4[j]   <= fold(arg_s3[j]);
				r2_s4[j]  <= fmul(fold(arg_s3[j]), fold(arg_s3[j]));
				t_s5[j]   <= ssub(C7, fmul(r2_s4[j], C9));
				t_s6[j]   <= ssub(C5, fmul(r2_s5[j], t_s5[j]));
				t_s7[j]   <= ssub(C3, fmul(r2_s6[j], t_s6[j]));
				t_s8[j]   <= ssub(ONE, fmul(r2_s7[j], t_s7[j]));
				sc_s9[j]  <= fmul(f_s8[j], t_s8[j]);
			end
			f_s5  <= f_s4;
			f_s6  <= f_s5;
			f_s7  <= f_s6;
			f_s8  <= f_s7;
			r2_s5 <= r2_s4;
			r2_s6 <= r2_s5;
			r2_s7 <= r2_s6;
			for (int k = 0; k < 2; k++) begin
				p_s10[k]   <= fmul(sc_s9[2*k], sc_s9[2*k+1]);
				q_s10[k]   <= fmul(sc_s9[2*k], sc_s9[2*k]);
				wsq_s10[k] <= fmul(pass_s[8].w[k], pass_s[8].w[k]);
				ml_s10[k]  <= fmul(m_f[k], l_f[k]);
				gs_s10[k]  <= fmul(g_f, sc_s9[2*k]);
				s_s10[k]   <= sc_s9[2*k];
				c_s10[k]   <= sc_s9[2*k+1];
				a_s11[k]   <= fmul(m_f[k], p_s10[k]);
				b_s11[k]   <= fmul(m_f[k], q_s10[k]);
				e_s11[k]   <= fmul(ml_s10[k], wsq_s10[k]);
				ct_s12[k]  <= fmul(e_s11[k], s_s11[k]);
			end
			s_s11    <= s_s10;
			c_s11    <= c_s10;
			gs_s11   <= gs_s10;
			gsum_s12 <= sadd(a_s11[0], a_s11[1]);
			den_s12  <= sadd(cm_f, sadd(b_s11[0], b_s11[1]));
			c_s12    <= c_s11;
			gs_s12   <= gs_s11;
			gt_s13   <= fmul(g_f, gsum_s12);
			ct_s13   <= ct_s12;
			den_s13  <= den_s12;
			c_s13    <= c_s12;
			gs_s13   <= gs_s12;
			num_s14  <= ssub(ssub(ssub(pass_s[12].frc, gt_s13), ct_s13[0]), ct_s13[1]);
			den_s14  <= den_s13;
			c_s14    <= c_s13;
			gs_s14   <= gs_s13;
		end
	end

	fix_t   acc;
	side1_t side1_q [DIV_LAT];

	cdpd_div u_div_acc (
		.clk (clk),
		.en  (en),
		.num (num_s14),
		.den (den_s14),
		.quo (acc)
	);

	fix_t [1:0] n_s15;
	side2_t     side2_s15;
	side2_t     side2_q [DIV_LAT];
	fix_t [1:0] dd;

	always_ff @(posedge clk) begin
		if (en) begin
			side1_q[0] <= '{pass: pass_s[PRE-1], c: c_s14, gs: gs_s14};
			for (int i = 1; i < DIV_LAT; i++) side1_q[i] <= side1_q[i-1];
			for (int k = 0; k < 2; k++) begin
				n_s15[k] <= ssub(fmul(acc, side1_q[DIV_LAT-1].c[k]), side1_q[DIV_LAT-1].gs[k]);
			end
			side2_s15  <= '{pass: side1_q[DIV_LAT-1].pass, acc: acc};
			side2_q[0] <= side2_s15;
			for (int i = 1; i < DIV_LAT; i++) side2_q[i] <= side2_q[i-1];
			d_position  <= side2_q[DIV_LAT-1].pass.vel;
			d_velocity  <= side2_q[DIV_LAT-1].acc;
			d_angle_one <= side2_q[DIV_LAT-1].pass.w[0];
			d_rate_one  <= dd[0];
			d_angle_two <= side2_q[DIV_LAT-1].pass.w[1];
			d_rate_two  <= dd[1];
		end
	end

	for (genvar k = 0; k < 2; k++) begin : g_lane
		cdpd_div u_div_rate (
			.clk (clk),
			.en  (en),
			.num (n_s15[k]),
			.den (l_f[k]),
			.quo (dd[k])
		);
	end

endmodule

[sim/cart_double_pendulum_derivative_tb.sv]
`timescale 1ns / 1ps

module cart_double_pendulum_derivative_tb;
	import cdpd_pkg::*;

	localparam longint LMAX = 64'sd2147483647;
	localparam longint LMIN = -64'sd2147483648;
	localparam int LAT = 68;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		fix_t frc, pos, vel, a1, w1, a2, w2;
	} state_vec_t;

	typedef struct packed {
		fix_t dp, dv, da1, dr1, da2, dr2;
	} deriv_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [IDX_W-1:0] cfg_index = '0;
	cfg_t cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	state_vec_t drv = '0;
	logic out_valid;
	logic out_stall = 0;
	deriv_t got;

	longint plant_reg [NUM_REGS];
	state_vec_t pending_q[$];
	deriv_t deriv_q[$];
	int send_idle_pct = 17, recv_idle_pct = 51;
	int errors = 0;
	int quiet_cycles = 0;
	bit hold_send = 0;

	always #6 clk = ~clk;

	cart_double_pendulum_derivative uut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall,
		.force_req(drv.frc), .cart_position(drv.pos), .cart_velocity(drv.vel),
		.angle_one(drv.a1), .rate_one(drv.w1), .angle_two(drv.a2), .rate_two(drv.w2),
		.out_valid, .out_stall,
		.d_position(got.dp), .d_velocity(got.dv), .d_angle_one(got.da1),
		.d_rate_one(got.dr1), .d_angle_two(got.da2), .d_rate_two(got.dr2)
	);

	function automatic longint clamp_w(input longint s);
		if (s > LMAX) return LMAX;
		if (s < LMIN) return LMIN;
		return s;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		logic [127:0] p;
		logic [63:0] ma, mb;
		bit neg;
		neg = (a < 0) != (b < 0);
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		p = ma * mb;
		p = p >> FB;
		if (p > 128'(LMAX)) return neg ? LMIN : LMAX;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint qdiv(input longint n, input longint d);
		logic [127:0] q;
		logic [63:0] mn, md;
		bit neg;
		if (d == 0) return n > 0 ? LMAX : (n < 0 ? LMIN : 0);
		neg = (n < 0) != (d < 0);
		mn = n < 0 ? -n : n;
		md = d < 0 ? -d : d;
		q = ({64'b0, mn} << FB) / md;
		if (q > 128'(LMAX)) return neg ? LMIN : LMAX;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint q30(input longint c);
		return (c + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
	endfunction

	function automatic longint wrap_angle(input longint x);
		longint pi, r;
		pi = q30(PI_Q30);
		r = x % (2 * pi);
		if (r < 0) r += 2 * pi;
		if (r > pi) r -= 2 * pi;
		return r;
	endfunction

	function automatic longint poly_sine(input longint r);
		longint pi, half, r2, t;
		pi = q30(PI_Q30);
		half = q30(HALF_PI_Q30);
		if (r > half) r = pi - r;
		if (r < -half) r = -pi - r;
		r2 = qmul(r, r);
		t = q30(INV362880_Q30);
		t = clamp_w(q30(INV5040_Q30) - qmul(r2, t));
		t = clamp_w(q30(INV120_Q30) - qmul(r2, t));
		t = clamp_w(q30(INV6_Q30) - qmul(r2, t));
		t = clamp_w((64'sd1 <<< FB) - qmul(r2, t));
		return qmul(r, t);
	endfunction

	function automatic longint poly_cosine(input longint x);
		longint r;
		r = wrap_angle(x) + q30(HALF_PI_Q30);
		if (r > q30(PI_Q30)) r -= 2 * q30(PI_Q30);
		return poly_sine(r);
	endfunction

	function automatic deriv_t plant_derivs(input state_vec_t v);
		longint cm, m1, m2, l1, l2, g, s1, c1, s2, c2, gt, ct1, ct2, num, den, acc;
		deriv_t d;
		cm = plant_reg[REG_CART_MASS];
		m1 = plant_reg[REG_MASS_ONE];
		m2 = plant_reg[REG_MASS_TWO];
		l1 = plant_reg[REG_LENGTH_ONE];
		l2 = plant_reg[REG_LENGTH_TWO];
		g = plant_reg[REG_GRAVITY];
		s1 = poly_sine(wrap_angle(longint'(v.a1)));
		c1 = poly_cosine(longint'(v.a1));
		s2 = poly_sine(wrap_angle(longint'(v.a2)));
		c2 = poly_cosine(longint'(v.a2));
		gt = qmul(g, clamp_w(qmul(m1, qmul(s1, c1)) + qmul(m2, qmul(s2, c2))));
		ct1 = qmul(qmul(qmul(m1, l1), qmul(v.w1, v.w1)), s1);
		ct2 = qmul(qmul(qmul(m2, l2), qmul(v.w2, v.w2)), s2);
		num = clamp_w(clamp_w(clamp_w(longint'(v.frc) - gt) - ct1) - ct2);
		den = clamp_w(cm + clamp_w(qmul(m1, qmul(s1, s1)) + qmul(m2, qmul(s2, s2))));
		acc = qdiv(num, den);
		d.dp = v.vel;
		d.dv = fix_t'(acc);
		d.da1 = v.w1;
		d.dr1 = fix_t'(qdiv(clamp_w(qmul(acc, c1) - qmul(g, s1)), l1));
		d.da2 = v.w2;
		d.dr2 = fix_t'(qdiv(clamp_w(qmul(acc, c2) - qmul(g, s2)), l2));
		return d;
	endfunction

	// driver
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			deriv_q.push_back(plant_derivs(drv));
		if (!in_valid || !in_stall) begin
			if (pending_q.size() > 0 && !hold_send &&
			    $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1;
				drv <= pending_q.pop_front();
			end else
				in_valid <= 0;
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (deriv_q.size() == 0) begin
				$display("%t unexpected result %h", $time, got);
				errors++;
			end else begin
				deriv_t e;
				e = deriv_q.pop_front();
				if (e.dp !== got.dp)
					$display("%t d_position exp %h got %h", $time, e.dp, got.dp);
				if (e.dv !== got.dv)
					$display("%t d_velocity exp %h got %h", $time, e.dv, got.dv);
				if (e.da1 !== got.da1)
					$display("%t d_angle_one exp %h got %h", $time, e.da1, got.da1);
				if (e.dr1 !== got.dr1)
					$display("%t d_rate_one exp %h got %h", $time, e.dr1, got.dr1);
				if (e.da2 !== got.da2)
					$display("%t d_angle_two exp %h got %h", $time, e.da2, got.da2);
				if (e.dr2 !== got.dr2)
					$display("%t d_rate_two exp %h got %h", $time, e.dr2, got.dr2);
				if (e !== got) errors++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic fix_t rand_word();
		case ($urandom_range(5))
			0: return fix_t'($urandom);
			1: return fix_t'($urandom_range(0, 1) ? FIX_MAX : FIX_MIN);
			2: return fix_t'(int'($urandom_range(0, 32'h60000)) - 32'sh30000);
			default: return fix_t'(int'($urandom_range(0, 32'h1A0000)) - 32'shD0000);
		endcase
	endfunction

	function automatic state_vec_t rand_state();
		state_vec_t v;
		v.frc = rand_word();
		v.pos = fix_t'($urandom);
		v.vel = fix_t'($urandom);
		v.a1 = rand_word();
		v.w1 = rand_word();
		v.a2 = rand_word();
		v.w2 = rand_word();
		return v;
	endfunction

	task automatic drain();
		wait (pending_q.size() == 0 && !in_valid && deriv_q.size() == 0);
		repeat (LAT + 5) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input cfg_t val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		plant_reg[idx] = longint'(val);
	endtask

	task automatic load_regs(input cfg_t cm, m1, m2, l1, l2, g);
		write_reg(REG_CART_MASS, cm);
		write_reg(REG_MASS_ONE, m1);
		write_reg(REG_MASS_TWO, m2);
		write_reg(REG_LENGTH_ONE, l1);
		write_reg(REG_LENGTH_TWO, l2);
		write_reg(REG_GRAVITY, g);
		// ignored index
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= IDX_W'(NUM_REGS + 1);
		cfg_data <= cfg_t'($urandom);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_batch(input int n);
		repeat (n) pending_q.push_back(rand_state());
	endtask

	initial begin
		state_vec_t v;
		plant_reg[REG_CART_MASS] = RST_CART_MASS;
		plant_reg[REG_MASS_ONE] = RST_MASS_ONE;
		plant_reg[REG_MASS_TWO] = RST_MASS_TWO;
		plant_reg[REG_LENGTH_ONE] = RST_LENGTH_ONE;
		plant_reg[REG_LENGTH_TWO] = RST_LENGTH_TWO;
		plant_reg[REG_GRAVITY] = RST_GRAVITY;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed: zeros, extremes, angles around pi and minus half pi
		pending_q.push_back('0);
		pending_q.push_back({7{FIX_MAX}});
		pending_q.push_back({7{FIX_MIN}});
		pending_q.push_back({7{32'shFFFFFFFF}});
		for (int i = 0; i < DW; i += 4) begin
			v = '0;
			v.a1 = fix_t'(q30(PI_Q30)) + fix_t'(i / 4 - 4);
			v.a2 = -fix_t'(q30(HALF_PI_Q30)) + fix_t'(i);
			v.w1 = 32'sh00030000;
			v.w2 = FIX_MIN;
			v.frc = fix_t'(1 << i);
			pending_q.push_back(v);
		end
		random_batch(500);
		drain();

		// zero cart mass, masses and lengths, then all-ones registers
		load_regs(31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd642908);
		random_batch(300);
		drain();
		load_regs('1, '1, '1, '1, '1, '1);
		random_batch(300);
		drain();

		send_idle_pct = 51;
		recv_idle_pct = 17;
		load_regs(31'd65536, '1, 31'd12345, 31'd65536, 31'd200000, 31'd642908);
		random_batch(350);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_regs(cfg_t'($urandom), cfg_t'($urandom), cfg_t'($urandom),
			31'd65536 + cfg_t'($urandom_range(0, 1 << 20)),
			31'd65536 + cfg_t'($urandom_range(0, 1 << 20)), cfg_t'($urandom));
		random_batch(200);
		wait (pending_q.size() <= 100);
		hold_send = 1;
		wait (deriv_q.size() == 0 && !in_valid);
		hold_send = 0;
		random_batch(180);
		drain();

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[cart_double_pendulum_derivative.f]
design/cdpd_pkg.sv
design/cdpd_div.sv
design/cart_double_pendulum_derivative.sv
sim/cart_double_pendulum_derivative_tb.sv
